// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== sv/hc_pkg.sv =====
package hc_pkg;

  typedef logic [4:0] letter_t;

  localparam letter_t MODULUS    = 5'd26;
  localparam letter_t PAD_LETTER = 5'd23;

  localparam logic [2:0] CFG_KEY_TL  = 3'd0;
  localparam logic [2:0] CFG_KEY_TR  = 3'd1;
  localparam logic [2:0] CFG_KEY_BL  = 3'd2;
  localparam logic [2:0] CFG_KEY_BR  = 3'd3;
  localparam logic [2:0] CFG_DIR     = 3'd4;

  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  typedef struct packed {
    letter_t p0;
    letter_t p1;
    logic    last;
  } pair_t;

  typedef struct packed {
    logic    ok;
    letter_t m00;
    letter_t m01;
    letter_t m10;
    letter_t m11;
  } kmat_t;

  function automatic letter_t red_letter(input logic [4:0] v);
    return (v >= MODULUS) ? v - MODULUS : v;
  endfunction

  function automatic letter_t mod26(input logic [10:0] v);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 23'(v) * 23'd2520;
    q    = prod[22:16];
    r    = v - 11'(11'(q) * 11'd26);
    if (r >= 11'd26) begin
      r = r - 11'd26;
    end
    return r[4:0];
  endfunction

  function automatic letter_t inv_det(input letter_t d);
    letter_t res;
    unique case (d)
      5'd1:    res = 5'd1;
      5'd3:    res = 5'd9;
      5'd5:    res = 5'd21;
      5'd7:    res = 5'd15;
      5'd9:    res = 5'd3;
      5'd11:   res = 5'd19;
      5'd15:   res = 5'd7;
      5'd17:   res = 5'd23;
      5'd19:   res = 5'd11;
      5'd21:   res = 5'd5;
      5'd23:   res = 5'd17;
      5'd25:   res = 5'd25;
      default: res = 5'd0;
    endcase
    return res;
  endfunction

  function automatic letter_t neg26(input letter_t x);
    return (x == 5'd0) ? 5'd0 : MODULUS - x;
  endfunction

endpackage

// ===== sv/hc_keysched.sv =====
module hc_keysched import hc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_wdata,
  output kmat_t      kmat
);

  letter_t     k_tl_r, k_tr_r, k_bl_r, k_br_r;
  logic        dir_r;
  logic [2:0]  settle_r;
  logic [9:0]  ad_r, bc_r;
  letter_t     det_r;
  letter_t     inv;
  logic [9:0]  pa_r, pb_r, pc_r, pd_r;
  letter_t     m00_r, m01_r, m10_r, m11_r;
  letter_t     wval;

  assign wval = red_letter(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_tl_r   <= 5'd9;
      k_tr_r   <= 5'd4;
      k_bl_r   <= 5'd5;
      k_br_r   <= 5'd7;
      dir_r    <= 1'b0;
      settle_r <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle_r <= SETTLE_CYCLES;
        unique case (cfg_index)
          CFG_KEY_TL: k_tl_r <= wval;
          CFG_KEY_TR: k_tr_r <= wval;
          CFG_KEY_BL: k_bl_r <= wval;
          CFG_KEY_BR: k_br_r <= wval;
          CFG_DIR:    dir_r  <= cfg_wdata[0];
          default:    ;
        endcase
      end else if (settle_r != 3'd0) begin
        settle_r <= settle_r - 3'd1;
      end
    end
  end

  assign inv = inv_det(det_r);

  always_ff @(posedge clk) begin
    ad_r  <= {5'b0, k_tl_r} * {5'b0, k_br_r};
    bc_r  <= {5'b0, k_tr_r} * {5'b0, k_bl_r};
    det_r <= mod26(11'(ad_r) + 11'd676 - 11'(bc_r));
    pa_r  <= {5'b0, inv} * {5'b0, k_tl_r};
    pb_r  <= {5'b0, inv} * {5'b0, k_tr_r};
    pc_r  <= {5'b0, inv} * {5'b0, k_bl_r};
    pd_r  <= {5'b0, inv} * {5'b0, k_br_r};
    m00_r <= dir_r ? mod26(11'(pd_r)) : k_tl_r;
    m01_r <= dir_r ? neg26(mod26(11'(pb_r))) : k_tr_r;
    m10_r <= dir_r ? neg26(mod26(11'(pc_r))) : k_bl_r;
    m11_r <= dir_r ? mod26(11'(pa_r)) : k_br_r;
  end

  assign kmat.ok  = (settle_r == 3'd0);
  assign kmat.m00 = m00_r;
  assign kmat.m01 = m01_r;
  assign kmat.m10 = m10_r;
  assign kmat.m11 = m11_r;

endmodule

// ===== sv/hc_front.sv =====
module hc_front import hc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_letter_in,
  input  logic       in_final_letter,
  output logic       push_valid,
  input  logic       push_ready,
  output pair_t      push_data
);

  logic    hold_r, hold_nxt;
  logic    pv_r, pv_nxt;
  letter_t held_r;
  pair_t   pair_r;
  letter_t letter;
  logic    accept;
  logic    closes;

  assign letter   = red_letter(in_letter_in);
  assign in_ready = !pv_r || push_ready;
  assign accept   = in_valid && in_ready;
  assign closes   = hold_r || in_final_letter;

  always_comb begin
    hold_nxt = hold_r;
    pv_nxt   = pv_r && !push_ready;
    if (accept) begin
      if (closes) begin
        pv_nxt   = 1'b1;
        hold_nxt = 1'b0;
      end else begin
        hold_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
      pv_r   <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !closes) begin
      held_r <= letter;
    end
    if (accept && closes) begin
      if (hold_r) begin
        pair_r <= '{p0: held_r, p1: letter, last: in_final_letter};
      end else begin
        pair_r <= '{p0: letter, p1: PAD_LETTER, last: 1'b1};
      end
    end
  end

  assign push_valid = pv_r;
  assign push_data  = pair_r;

endmodule

// ===== sv/hc_queue.sv =====
module hc_queue import hc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  pair_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output pair_t pop_data
);

  pair_t      mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/hc_back.sv =====
`include "assert_macros.svh"

module hc_back import hc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  kmat_t      kmat,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  pair_t      pop_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_letter_out,
  output logic       out_final_out
);

  logic        x_valid_r, x_valid_nxt;
  logic [10:0] x_s0_r, x_s1_r;
  logic        x_last_r;
  logic        y_valid_r, y_valid_nxt;
  logic        y_phase_r, y_phase_nxt;
  letter_t     y_l0_r, y_l1_r;
  logic        y_last_r;
  logic        y_load, x_adv, pop_fire;

  assign y_load    = !y_valid_r || (out_ready && y_phase_r);
  assign x_adv     = !x_valid_r || y_load;
  assign pop_ready = x_adv && kmat.ok;
  assign pop_fire  = pop_valid && pop_ready;

  always_comb begin
    x_valid_nxt = x_adv ? pop_fire : x_valid_r;
    y_valid_nxt = y_valid_r;
    y_phase_nxt = y_phase_r;
    if (y_load) begin
      y_valid_nxt = x_valid_r;
      y_phase_nxt = 1'b0;
    end else if (out_ready) begin
      y_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r <= 1'b0;
      y_valid_r <= 1'b0;
      y_phase_r <= 1'b0;
    end else begin
      x_valid_r <= x_valid_nxt;
      y_valid_r <= y_valid_nxt;
      y_phase_r <= y_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      x_s0_r   <= {6'b0, kmat.m00} * {6'b0, pop_data.p0}
                + {6'b0, kmat.m01} * {6'b0, pop_data.p1};
      x_s1_r   <= {6'b0, kmat.m10} * {6'b0, pop_data.p0}
                + {6'b0, kmat.m11} * {6'b0, pop_data.p1};
      x_last_r <= pop_data.last;
    end
    if (y_load) begin
      y_l0_r   <= mod26(x_s0_r);
      y_l1_r   <= mod26(x_s1_r);
      y_last_r <= x_last_r;
    end
  end

  assign out_valid      = y_valid_r;
  assign out_letter_out = y_phase_r ? y_l1_r : y_l0_r;
  assign out_final_out  = y_phase_r && y_last_r;

  `ASSERT_CLK(a_phase_valid, clk, rst_n, y_phase_r |-> y_valid_r)
  `ASSERT_CLK(a_drain, clk, rst_n, (y_valid_r && y_phase_r && out_ready && !x_valid_r) |=> !y_valid_r)
  `ASSERT_CLK(a_x_hold, clk, rst_n, (x_valid_r && !y_load) |=> (x_valid_r && $stable(x_s0_r)))

endmodule

// ===== sv/hill_cipher_2x2.sv =====
// channel  handshake           payload
// in       in_valid/in_ready   in_letter_in, in_final_letter
// out      out_valid/out_ready out_letter_out, out_final_out
// cfg      cfg_we              cfg_index, cfg_wdata
//
// One letter in per cycle while out_ready is high and kmat.ok; pairs leave as two letters.
// A closed pair passes the front register, the queue, then the x and y registers.
// rst_n is synchronous; after reset or any cfg write the key pipeline settles while
// settle_r counts down, during which letters are still taken but no pair leaves the queue.
// A two-entry pair queue lets the front and back stall independently.
module hill_cipher_2x2 import hc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_letter_in,
  input  logic       in_final_letter,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_letter_out,
  output logic       out_final_out,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  kmat_t kmat;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  pair_t push_data, pop_data;

  hc_keysched u_keysched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .kmat      (kmat)
  );

  hc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_letter_in    (in_letter_in),
    .in_final_letter (in_final_letter),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  hc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .kmat           (kmat),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_letter_out (out_letter_out),
    .out_final_out  (out_final_out)
  );

endmodule
